// ===== rtl/latest_frame_slot_manager_unit_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef LATEST_FRAME_SLOT_MANAGER_UNIT_MACROS_SVH
`define LATEST_FRAME_SLOT_MANAGER_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define LFSM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfsm check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define LFSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfsm check failed");

`endif

// ===== rtl/lfsm_pkg.sv =====
package lfsm_pkg;

    localparam int SLOT_COUNT_DEF = 3;

    localparam int REQ_W     = 2;
    localparam int HANDLE_W  = 32;
    localparam int SLOT_IN_W = 4;
    localparam int STATUS_W  = 3;
    localparam int SEQ_W     = 32;
    localparam int DROP_W    = 32;
    localparam int FAIL_W    = 8;

    localparam int APB_AW = 2;
    localparam int APB_DW = 32;

    localparam logic [FAIL_W-1:0] MAX_FAIL_RESET = 8'd30;
    localparam logic [APB_AW-1:0] ADDR_MAX_FAILURES = 2'd0;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUBLISH = 2'd0,
        REQ_FAILURE = 2'd1,
        REQ_ACQUIRE = 2'd2,
        REQ_RELEASE = 2'd3
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_NO_NEW   = 3'd1,
        ST_FATAL    = 3'd2,
        ST_NO_SLOT  = 3'd3,
        ST_BAD_SLOT = 3'd4,
        ST_IGNORED  = 3'd5
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

// ===== rtl/lfsm_cfg.sv =====
module lfsm_cfg
    import lfsm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [FAIL_W-1:0] max_failures
);

    logic [FAIL_W-1:0] max_fail_reg;
    logic [FAIL_W-1:0] max_fail_next;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr == ADDR_MAX_FAILURES);

    always_comb
    begin
        max_fail_next = max_fail_reg;
        if (wr_en)
        begin
            max_fail_next = pwdata[FAIL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_fail_reg <= MAX_FAIL_RESET;
        end
        else
        begin
            max_fail_reg <= max_fail_next;
        end
    end

    assign prdata       = (paddr == ADDR_MAX_FAILURES) ?
                          {{(APB_DW-FAIL_W){1'b0}}, max_fail_reg} : '0;
    assign max_failures = max_fail_reg;

endmodule

// ===== rtl/lfsm_ctrl.sv =====
module lfsm_ctrl
    import lfsm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        out_valid_reg;
    logic        out_valid_next;

    assign in_ready = (state_reg == S_IDLE);
    assign cmd.load = in_valid && in_ready;
    // Commit only when the output register is empty or being drained.
    assign cmd.exec = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.exec)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/lfsm_dp.sv =====
module lfsm_dp
    import lfsm_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    input  logic [FAIL_W-1:0]    max_failures,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [HANDLE_W-1:0]  frame_handle,
    input  logic [SLOT_IN_W-1:0] slot_in,
    output logic [STATUS_W-1:0]  status,
    output logic [SLOT_IN_W-1:0] slot_out,
    output logic [HANDLE_W-1:0]  handle_out,
    output logic [SEQ_W-1:0]     frame_seq,
    output logic [DROP_W-1:0]    dropped_total,
    output logic                 fatal
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    // Captured item
    req_t                 req_reg;
    logic [HANDLE_W-1:0]  handle_reg;
    logic [SLOT_IN_W-1:0] rel_reg;

    // Slot state
    logic [SLOT_COUNT-1:0] busy_reg,  busy_next;
    logic [SLOT_COUNT-1:0] full_reg,  full_next;
    logic [SEQ_W-1:0]      slot_seq_reg [SLOT_COUNT];
    logic [HANDLE_W-1:0]   slot_hdl_reg [SLOT_COUNT];
    logic                  slot_wr;
    logic                  newest_valid_reg, newest_valid_next;
    logic [IDX_W-1:0]      newest_reg, newest_next;
    logic [SEQ_W-1:0]      next_seq_reg, next_seq_next;
    logic [SEQ_W-1:0]      taken_seq_reg, taken_seq_next;
    logic [DROP_W-1:0]     drop_reg, drop_next;
    logic [FAIL_W-1:0]     fail_run_reg, fail_run_next;
    logic                  fatal_reg, fatal_next;

    // Result register
    status_t              status_reg, status_next;
    logic [SLOT_IN_W-1:0] slot_out_reg, slot_out_next;
    logic [HANDLE_W-1:0]  hout_reg, hout_next;
    logic [SEQ_W-1:0]     seq_out_reg, seq_out_next;

    // Slot selection
    logic [SLOT_COUNT-1:0] free_vec;
    logic [SLOT_COUNT-1:0] unbusy_vec;
    logic [IDX_W-1:0]      free_idx;
    logic [IDX_W-1:0]      unbusy_idx;
    logic [IDX_W-1:0]      pick_idx;
    logic                  pick_ok;
    logic                  pick_drop;
    logic [IDX_W-1:0]      keep_idx;
    logic [SLOT_COUNT-1:0] disc_vec;
    logic [CNT_W-1:0]      disc_cnt;
    logic [CNT_W:0]        drop_add;
    logic [DROP_W:0]       drop_sum;
    logic                  acq_ok;
    logic [FAIL_W-1:0]     fail_inc;
    logic                  rel_ok;

    assign free_vec   = ~busy_reg & ~full_reg;
    assign unbusy_vec = ~busy_reg;

    // Lowest set index of each candidate vector
    always_comb
    begin
        free_idx   = '0;
        unbusy_idx = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--)
        begin
            if (free_vec[i])
            begin
                free_idx = IDX_W'(i);
            end
            if (unbusy_vec[i])
            begin
                unbusy_idx = IDX_W'(i);
            end
        end
    end

    // Free slot first, then the unclaimed newest, then any unclaimed slot.
    always_comb
    begin
        pick_idx  = '0;
        pick_ok   = 1'b1;
        pick_drop = 1'b0;
        priority if (|free_vec)
        begin
            pick_idx = free_idx;
        end
        else if (newest_valid_reg && !busy_reg[newest_reg])
        begin
            pick_idx  = newest_reg;
            pick_drop = 1'b1;
        end
        else if (|unbusy_vec)
        begin
            pick_idx  = unbusy_idx;
            pick_drop = 1'b1;
        end
        else
        begin
            pick_ok   = 1'b0;
            pick_drop = 1'b1;
        end
    end

    assign keep_idx = (req_reg == REQ_PUBLISH) ? pick_idx : newest_reg;
    assign disc_vec = ~busy_reg & full_reg & ~(SLOT_COUNT'(1) << keep_idx);

    always_comb
    begin
        disc_cnt = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            disc_cnt = disc_cnt + CNT_W'(disc_vec[i]);
        end
    end

    assign acq_ok = newest_valid_reg && full_reg[newest_reg] &&
                    (slot_seq_reg[newest_reg] != taken_seq_reg);
    assign fail_inc = (fail_run_reg == '1) ? fail_run_reg : fail_run_reg + 1'b1;
    assign rel_ok   = ({1'b0, rel_reg} < (SLOT_IN_W + 1)'(SLOT_COUNT));

    always_comb
    begin
        drop_add = '0;
        unique case (req_reg)
            REQ_PUBLISH:
            begin
                if (!fatal_reg)
                begin
                    drop_add = (CNT_W + 1)'(pick_drop) +
                               (CNT_W + 1)'(pick_ok ? disc_cnt : '0);
                end
            end
            REQ_ACQUIRE:
            begin
                if (!fatal_reg && acq_ok)
                begin
                    drop_add = (CNT_W + 1)'(disc_cnt);
                end
            end
            default:
            begin
                drop_add = '0;
            end
        endcase
    end

    // Saturate at all ones
    assign drop_sum = {1'b0, drop_reg} + (DROP_W + 1)'(drop_add);

    always_comb
    begin
        busy_next         = busy_reg;
        full_next         = full_reg;
        slot_wr           = 1'b0;
        newest_valid_next = newest_valid_reg;
        newest_next       = newest_reg;
        next_seq_next     = next_seq_reg;
        taken_seq_next    = taken_seq_reg;
        drop_next         = drop_reg;
        fail_run_next     = fail_run_reg;
        fatal_next        = fatal_reg;
        status_next       = status_reg;
        slot_out_next     = slot_out_reg;
        hout_next         = hout_reg;
        seq_out_next      = seq_out_reg;

        if (cmd.exec)
        begin
            status_next   = ST_OK;
            slot_out_next = '0;
            hout_next     = '0;
            seq_out_next  = '0;
            drop_next     = drop_sum[DROP_W] ? '1 : drop_sum[DROP_W-1:0];
            unique case (req_reg)
                REQ_PUBLISH:
                begin
                    if (fatal_reg)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else
                    begin
                        fail_run_next = '0;
                        if (pick_ok)
                        begin
                            slot_wr           = 1'b1;
                            next_seq_next     = next_seq_reg + 1'b1;
                            full_next         = (full_reg & ~disc_vec) |
                                                (SLOT_COUNT'(1) << pick_idx);
                            newest_valid_next = 1'b1;
                            newest_next       = pick_idx;
                            slot_out_next     = SLOT_IN_W'(pick_idx);
                            seq_out_next      = next_seq_reg;
                        end
                        else
                        begin
                            status_next = ST_NO_SLOT;
                        end
                    end
                end
                REQ_FAILURE:
                begin
                    if (fatal_reg)
                    begin
                        status_next = ST_IGNORED;
                    end
                    else
                    begin
                        fail_run_next = fail_inc;
                        if (fail_inc >= max_failures)
                        begin
                            fatal_next  = 1'b1;
                            status_next = ST_FATAL;
                        end
                    end
                end
                REQ_ACQUIRE:
                begin
                    priority if (fatal_reg)
                    begin
                        status_next = ST_FATAL;
                    end
                    else if (!acq_ok)
                    begin
                        status_next = ST_NO_NEW;
                    end
                    else
                    begin
                        full_next             = full_reg & ~disc_vec;
                        full_next[newest_reg] = 1'b0;
                        busy_next[newest_reg] = 1'b1;
                        taken_seq_next        = slot_seq_reg[newest_reg];
                        newest_valid_next     = 1'b0;
                        slot_out_next         = SLOT_IN_W'(newest_reg);
                        hout_next             = slot_hdl_reg[newest_reg];
                        seq_out_next          = slot_seq_reg[newest_reg];
                    end
                end
                REQ_RELEASE:
                begin
                    if (rel_ok)
                    begin
                        busy_next[rel_reg[IDX_W-1:0]] = 1'b0;
                    end
                    else
                    begin
                        status_next = ST_BAD_SLOT;
                    end
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg    <= req_t'(req_type);
            handle_reg <= frame_handle;
            rel_reg    <= slot_in;
        end
        if (slot_wr)
        begin
            slot_hdl_reg[pick_idx] <= handle_reg;
            slot_seq_reg[pick_idx] <= next_seq_reg;
        end
        status_reg   <= status_next;
        slot_out_reg <= slot_out_next;
        hout_reg     <= hout_next;
        seq_out_reg  <= seq_out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= '0;
            full_reg         <= '0;
            newest_valid_reg <= 1'b0;
            newest_reg       <= '0;
            next_seq_reg     <= SEQ_W'(1);
            taken_seq_reg    <= '0;
            drop_reg         <= '0;
            fail_run_reg     <= '0;
            fatal_reg        <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            full_reg         <= full_next;
            newest_valid_reg <= newest_valid_next;
            newest_reg       <= newest_next;
            next_seq_reg     <= next_seq_next;
            taken_seq_reg    <= taken_seq_next;
            drop_reg         <= drop_next;
            fail_run_reg     <= fail_run_next;
            fatal_reg        <= fatal_next;
        end
    end

    assign status        = status_reg;
    assign slot_out      = slot_out_reg;
    assign handle_out    = hout_reg;
    assign frame_seq     = seq_out_reg;
    assign dropped_total = drop_reg;
    assign fatal         = fatal_reg;

endmodule

// ===== rtl/latest_frame_slot_manager_unit.sv =====
// Latest-frame mailbox over SLOT_COUNT frame slots. Each request (publish,
// capture failure, acquire latest, release slot) yields exactly one result.
// A request is first captured from the transfer, then a decision step does the
// slot selection, drop count and state update and writes the result to the
// output register. The next request is taken while that result waits; a
// request stalls in its decision step only while the output register still
// holds an untaken result. max_failures sits at byte 0 of the APB port and
// resets to 30.
module latest_frame_slot_manager_unit
    import lfsm_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [REQ_W-1:0]     req_type,
    input  logic [HANDLE_W-1:0]  frame_handle,
    input  logic [SLOT_IN_W-1:0] slot_in,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [STATUS_W-1:0]  status,
    output logic [SLOT_IN_W-1:0] slot_out,
    output logic [HANDLE_W-1:0]  handle_out,
    output logic [SEQ_W-1:0]     frame_seq,
    output logic [DROP_W-1:0]    dropped_total,
    output logic                 fatal,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    cmd_t              cmd;
    logic [FAIL_W-1:0] max_failures;

    lfsm_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .max_failures (max_failures)
    );

    lfsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lfsm_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .max_failures  (max_failures),
        .req_type      (req_type),
        .frame_handle  (frame_handle),
        .slot_in       (slot_in),
        .status        (status),
        .slot_out      (slot_out),
        .handle_out    (handle_out),
        .frame_seq     (frame_seq),
        .dropped_total (dropped_total),
        .fatal         (fatal)
    );

endmodule

// ===== rtl/lfsm_checker.sv =====
`include "latest_frame_slot_manager_unit_macros.svh"

module lfsm_checker
    import lfsm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [STATUS_W-1:0]  status,
    input logic [SLOT_IN_W-1:0] slot_out,
    input logic [HANDLE_W-1:0]  handle_out,
    input logic [SEQ_W-1:0]     frame_seq,
    input logic                 fatal
);

    // Hold a stalled result.
    `LFSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status))

    // One request in flight: the cycle after a transfer is spent deciding.
    `LFSM_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready)

    // Only a successful publish or acquire carries slot and sequence, and only an acquire a handle.
    `LFSM_ASSERT_NOW(a_fail_zero, out_valid && status != ST_OK, slot_out == '0 && handle_out == '0 && frame_seq == '0)

    // An ignored request implies the fatal flag is set.
    `LFSM_ASSERT_NOW(a_ignored_fatal, out_valid && status == ST_IGNORED, fatal)

    // Fatal is sticky.
    `LFSM_ASSERT_NEXT(a_fatal_sticky, fatal, fatal)

endmodule

bind latest_frame_slot_manager_unit lfsm_checker u_lfsm_checker (.*);

// ===== dv/latest_frame_slot_manager_unit_tb.sv =====
module latest_frame_slot_manager_unit_tb;
    import lfsm_pkg::*;

    localparam int NSLOT       = SLOT_COUNT_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_AT     = 260;
    localparam int HOLD_LEN    = 150;

    typedef struct packed {
        status_t              st;
        logic [SLOT_IN_W-1:0] slot;
        logic [HANDLE_W-1:0]  hdl;
        logic [SEQ_W-1:0]     seq;
        logic [DROP_W-1:0]    drops;
        logic                 fat;
    } frame_result_t;

    typedef struct {
        req_t                 kind;
        logic [HANDLE_W-1:0]  hdl;
        logic [SLOT_IN_W-1:0] rel;
        bit                   typed;
        frame_result_t        want;
    } mailbox_row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 in_valid     = 1'b0;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type     = '0;
    logic [HANDLE_W-1:0]  frame_handle = '0;
    logic [SLOT_IN_W-1:0] slot_in      = '0;
    logic                 out_valid;
    logic                 out_ready    = 1'b0;
    logic [STATUS_W-1:0]  status;
    logic [SLOT_IN_W-1:0] slot_out;
    logic [HANDLE_W-1:0]  handle_out;
    logic [SEQ_W-1:0]     frame_seq;
    logic [DROP_W-1:0]    dropped_total;
    logic                 fatal;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [APB_AW-1:0]    paddr        = '0;
    logic [APB_DW-1:0]    pwdata       = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // travels with the payload: typed-in expectation for directed rows
    bit            row_typed = 1'b0;
    frame_result_t row_want  = '0;

    // mailbox predictor state
    logic [NSLOT-1:0]    mb_claimed;
    logic [NSLOT-1:0]    mb_stored;
    logic [SEQ_W-1:0]    mb_tag [NSLOT];
    logic [HANDLE_W-1:0] mb_frame [NSLOT];
    logic                mb_newest_ok;
    int                  mb_newest;
    logic [SEQ_W-1:0]    mb_next_tag;
    logic [SEQ_W-1:0]    mb_taken_tag;
    logic [DROP_W-1:0]   mb_drops;
    logic [FAIL_W-1:0]   mb_fail_run;
    logic [FAIL_W-1:0]   mb_fail_limit;
    logic                mb_fatal;

    frame_result_t pending [$];
    mailbox_row_t  script [$];
    int            lead_count;
    int            errors       = 0;
    int            results_seen = 0;
    int            n_accepted   = 0;
    int            n_claims     = 0;
    int            n_no_slot    = 0;
    int            fail_streak  = 0;
    int            burst_left   = 0;
    bit            sender_idles = 1'b1;
    int            cycles       = 0;

    latest_frame_slot_manager_unit i_dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 40)
            $display("mismatch on %s at result %0d: got %0h, expected %0h",
                     what, results_seen, got, want);
        errors++;
    endtask

    function automatic void bump_drops();
        if (mb_drops != '1)
            mb_drops = mb_drops + 1'b1;
    endfunction

    // drop every unclaimed stored frame other than keep
    function automatic void flush_stale(input int keep);
        for (int i = 0; i < NSLOT; i++)
        begin
            if (i != keep && !mb_claimed[i] && mb_stored[i])
            begin
                mb_stored[i] = 1'b0;
                bump_drops();
            end
        end
    endfunction

    // free slot first, then the unclaimed newest, then the lowest unclaimed
    function automatic int choose_slot();
        for (int i = 0; i < NSLOT; i++)
            if (!mb_claimed[i] && !mb_stored[i])
                return i;
        if (mb_newest_ok && !mb_claimed[mb_newest])
        begin
            bump_drops();
            return mb_newest;
        end
        for (int i = 0; i < NSLOT; i++)
        begin
            if (!mb_claimed[i])
            begin
                if (mb_stored[i])
                    bump_drops();
                return i;
            end
        end
        return NSLOT;
    endfunction

    function automatic frame_result_t mailbox_step(input req_t kind,
                                                   input logic [HANDLE_W-1:0] hdl,
                                                   input logic [SLOT_IN_W-1:0] rel);
        frame_result_t r;
        int            s;
        r = '0;
        case (kind)
            REQ_PUBLISH:
            begin
                if (mb_fatal)
                    r.st = ST_IGNORED;
                else
                begin
                    mb_fail_run = '0;
                    s = choose_slot();
                    if (s >= NSLOT)
                    begin
                        bump_drops();
                        r.st = ST_NO_SLOT;
                    end
                    else
                    begin
                        mb_frame[s]  = hdl;
                        mb_tag[s]    = mb_next_tag;
                        mb_next_tag  = mb_next_tag + 1'b1;
                        mb_stored[s] = 1'b1;
                        mb_newest_ok = 1'b1;
                        mb_newest    = s;
                        flush_stale(s);
                        r.slot = SLOT_IN_W'(s);
                        r.seq  = mb_tag[s];
                    end
                end
            end
            REQ_FAILURE:
            begin
                if (mb_fatal)
                    r.st = ST_IGNORED;
                else
                begin
                    if (mb_fail_run != '1)
                        mb_fail_run = mb_fail_run + 1'b1;
                    if (mb_fail_run >= mb_fail_limit)
                    begin
                        mb_fatal = 1'b1;
                        r.st     = ST_FATAL;
                    end
                end
            end
            REQ_ACQUIRE:
            begin
                if (mb_fatal)
                    r.st = ST_FATAL;
                else if (!mb_newest_ok || !mb_stored[mb_newest] ||
                         mb_tag[mb_newest] == mb_taken_tag)
                    r.st = ST_NO_NEW;
                else
                begin
                    s = mb_newest;
                    flush_stale(s);
                    mb_claimed[s] = 1'b1;
                    mb_stored[s]  = 1'b0;
                    mb_taken_tag  = mb_tag[s];
                    mb_newest_ok  = 1'b0;
                    r.slot = SLOT_IN_W'(s);
                    r.hdl  = mb_frame[s];
                    r.seq  = mb_tag[s];
                end
            end
            REQ_RELEASE:
            begin
                if (rel >= NSLOT)
                    r.st = ST_BAD_SLOT;
                else
                    mb_claimed[rel] = 1'b0;
            end
        endcase
        r.drops = mb_drops;
        r.fat   = mb_fatal;
        return r;
    endfunction

    function automatic void add_row(input req_t kind, input logic [HANDLE_W-1:0] hdl,
                                    input logic [SLOT_IN_W-1:0] rel);
        mailbox_row_t row;
        row.kind  = kind;
        row.hdl   = hdl;
        row.rel   = rel;
        row.typed = 1'b0;
        row.want  = '0;
        script.push_back(row);
    endfunction

    function automatic void add_known(input req_t kind, input logic [HANDLE_W-1:0] hdl,
                                      input logic [SLOT_IN_W-1:0] rel, input status_t st,
                                      input logic [SLOT_IN_W-1:0] slot,
                                      input logic [SEQ_W-1:0] seq);
        mailbox_row_t row;
        row.kind       = kind;
        row.hdl        = hdl;
        row.rel        = rel;
        row.typed      = 1'b1;
        row.want       = '0;
        row.want.st    = st;
        row.want.slot  = slot;
        row.want.seq   = seq;
        script.push_back(row);
    endfunction

    // predict on each input transfer, check each output transfer
    always @(posedge clk)
    begin : check_results
        frame_result_t predicted;
        frame_result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predicted = mailbox_step(req_t'(req_type), frame_handle, slot_in);
                pending.push_back(row_typed ? row_want : predicted);
                n_accepted++;
                if (req_t'(req_type) == REQ_ACQUIRE && predicted.st == ST_OK)
                    n_claims++;
                if (predicted.st == ST_NO_SLOT)
                    n_no_slot++;
            end
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (pending.size() == 0)
                    report_mismatch("result with nothing pending", 32'(status), '0);
                else
                begin
                    want = pending.pop_front();
                    if (status !== want.st)
                        report_mismatch("status", 32'(status), 32'(want.st));
                    if (slot_out !== want.slot)
                        report_mismatch("slot_out", 32'(slot_out), 32'(want.slot));
                    if (handle_out !== want.hdl)
                        report_mismatch("handle_out", handle_out, want.hdl);
                    if (frame_seq !== want.seq)
                        report_mismatch("frame_seq", frame_seq, want.seq);
                    if (dropped_total !== want.drops)
                        report_mismatch("dropped_total", dropped_total, want.drops);
                    if (fatal !== want.fat)
                        report_mismatch("fatal", 32'(fatal), 32'(want.fat));
                end
            end
        end
    end

    // receiver: picks a new ready pattern whenever rx_tick wraps, plus one long hold-off
    logic [4:0] rx_tick   = '0;
    logic [1:0] rx_mode   = '0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;

    always @(posedge clk)
    begin
        rx_tick <= rx_tick + 1'b1;
        if (rx_tick == '0)
            rx_mode <= 2'($urandom_range(3, 0));
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            out_ready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
        else
        begin
            case (rx_mode)
                2'd0: out_ready <= 1'b1;
                2'd1: out_ready <= ($urandom_range(3, 0) != 0);
                2'd2: out_ready <= rx_tick[0];
                default: out_ready <= ($urandom_range(7, 0) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // offer one request and hold it until the transfer
    task automatic offer(input mailbox_row_t row);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(2, 0) == 0 || !sender_idles) ? 0 : $urandom_range(6, 1);
            if (gap > 0)
            begin
                if (in_valid)
                    in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(24, 1);
        end
        burst_left--;
        if (row.kind == REQ_PUBLISH)
            fail_streak = 0;
        else if (row.kind == REQ_FAILURE)
            fail_streak++;
        in_valid     <= 1'b1;
        req_type     <= row.kind;
        frame_handle <= row.hdl;
        slot_in      <= row.rel;
        row_typed    <= row.typed;
        row_want     <= row.want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // stop offering until every expected result has come back
    task automatic drain();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic cfg_access(input bit wr, input logic [FAIL_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_MAX_FAILURES;
        pwdata  <= APB_DW'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (wr)
            mb_fail_limit = val;
        else if (prdata[FAIL_W-1:0] !== val)
            report_mismatch("max_failures readback", prdata, 32'(val));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic cfg_set(input logic [FAIL_W-1:0] val);
        cfg_access(1'b1, val);
        @(posedge clk);
        cfg_access(1'b0, val);
    endtask

    task automatic run_random(input int count, input int w_pub, input int w_fail,
                              input int w_acq, input int w_rel, input int drain_at);
        mailbox_row_t row;
        int           pick;
        for (int n = 0; n < count; n++)
        begin
            if (n == drain_at)
                drain();
            row.typed = 1'b0;
            row.want  = '0;
            pick = $urandom_range(w_pub + w_fail + w_acq + w_rel - 1, 0);
            if (pick < w_pub)
                row.kind = REQ_PUBLISH;
            else if (pick < w_pub + w_fail)
                row.kind = REQ_FAILURE;
            else if (pick < w_pub + w_fail + w_acq)
                row.kind = REQ_ACQUIRE;
            else
                row.kind = REQ_RELEASE;
            // keep the failure run one short of the limit until the closing rows
            if (row.kind == REQ_FAILURE && fail_streak + 1 >= int'(mb_fail_limit))
                row.kind = REQ_PUBLISH;
            case ($urandom_range(7, 0))
                0: row.hdl = '0;
                1: row.hdl = '1;
                default: row.hdl = $urandom();
            endcase
            if ($urandom_range(7, 0) == 0)
                row.rel = SLOT_IN_W'($urandom_range(15, 0));
            else
                row.rel = SLOT_IN_W'($urandom_range(NSLOT - 1, 0));
            offer(row);
        end
    endtask

    initial
    begin : stimulus
        int lim_a;
        int lim_b;
        mb_claimed    = '0;
        mb_stored     = '0;
        mb_newest_ok  = 1'b0;
        mb_newest     = 0;
        mb_next_tag   = 1;
        mb_taken_tag  = '0;
        mb_drops      = '0;
        mb_fail_run   = '0;
        mb_fail_limit = MAX_FAIL_RESET;
        mb_fatal      = 1'b0;
        lim_a = $urandom_range(40, 3);
        lim_b = $urandom_range(255, 1);

        // opening rows: empty mailbox, bad slots, fill every slot, reuse newest
        add_known(REQ_ACQUIRE, '0, '0, ST_NO_NEW, '0, '0);
        add_known(REQ_RELEASE, '0, 4'd15, ST_BAD_SLOT, '0, '0);
        add_known(REQ_RELEASE, '0, 4'd3, ST_BAD_SLOT, '0, '0);
        add_known(REQ_RELEASE, '0, 4'd0, ST_OK, '0, '0);
        add_known(REQ_FAILURE, '0, '0, ST_OK, '0, '0);
        add_known(REQ_PUBLISH, '0, '0, ST_OK, 4'd0, 32'd1);
        add_row(REQ_PUBLISH, '1, 4'd1);
        add_row(REQ_ACQUIRE, '0, '0);
        add_row(REQ_ACQUIRE, '0, '0);
        add_row(REQ_PUBLISH, 32'h5a5a_5a5a, 4'd2);
        add_row(REQ_ACQUIRE, '0, '0);
        add_row(REQ_PUBLISH, 32'h1234_5678, 4'd0);
        add_row(REQ_ACQUIRE, '0, '0);
        add_row(REQ_PUBLISH, 32'hdead_beef, 4'd0);
        add_row(REQ_RELEASE, '0, 4'd1);
        add_row(REQ_PUBLISH, 32'h8000_0000, 4'd0);
        add_row(REQ_PUBLISH, 32'h7fff_ffff, 4'd0);
        add_row(REQ_RELEASE, '0, 4'd1);
        add_row(REQ_RELEASE, '0, 4'd0);
        add_row(REQ_RELEASE, '0, 4'd2);
        add_row(REQ_FAILURE, '0, '0);
        add_row(REQ_FAILURE, '0, '0);
        add_row(REQ_PUBLISH, 32'h0000_0001, 4'd0);
        add_row(REQ_ACQUIRE, '0, '0);
        add_row(REQ_RELEASE, '0, 4'd8);
        lead_count = script.size();
        // closing rows at a limit of one: go fatal, then everything after it
        add_row(REQ_FAILURE, '0, '0);
        add_row(REQ_PUBLISH, 32'hcafe_f00d, 4'd0);
        add_row(REQ_FAILURE, '0, '0);
        add_row(REQ_ACQUIRE, '0, '0);
        add_row(REQ_RELEASE, '0, 4'd0);
        add_row(REQ_RELEASE, '0, 4'd1);
        add_row(REQ_RELEASE, '0, 4'd12);
        add_row(REQ_PUBLISH, '1, 4'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_access(1'b0, MAX_FAIL_RESET);
        @(posedge clk);
        for (int i = 0; i < lead_count; i++)
            offer(script[i]);

        drain();
        cfg_set(8'd255);
        run_random(180, 4, 3, 3, 3, -1);

        // no sender gaps here, so the long receiver hold-off backs up the input
        drain();
        cfg_set(8'd2);
        sender_idles = 1'b0;
        run_random(170, 3, 2, 3, 1, 80);
        sender_idles = 1'b1;

        drain();
        cfg_set(FAIL_W'(lim_a));
        run_random(180, 5, 2, 2, 2, -1);

        drain();
        cfg_set(FAIL_W'(lim_b));
        run_random(170, 4, 2, 3, 3, 90);

        drain();
        cfg_set(8'd1);
        for (int i = lead_count; i < script.size(); i++)
            offer(script[i]);

        drain();
        repeat (8) @(posedge clk);
        $display("Covered %0d requests: %0d frames claimed, %0d publishes with every slot held.",
                 n_accepted, n_claims, n_no_slot);
        $display("Fail limits 30, 255, 2, %0d, %0d and 1, a long output stall, fatal lock-out.",
                 lim_a, lim_b);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
